@@ hdl/tmc_pkg.sv @@
`timescale 1ns / 1ps

package tmc_pkg;

    // field widths
    localparam int TEMP_W     = 12;
    localparam int KEY_W      = 8;
    localparam int SP_W       = 7;
    localparam int FINE_W     = 4;
    localparam int COARSE_W   = 5;
    localparam int BAND_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FINE_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COARSE_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_BAND  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_BAND  = 3'd5;

    // reset values
    localparam logic [SP_W-1:0]     LOW_LIMIT_RST   = 7'd20;
    localparam logic [SP_W-1:0]     HIGH_LIMIT_RST  = 7'd80;
    localparam logic [FINE_W-1:0]   FINE_STEP_RST   = 4'd1;
    localparam logic [COARSE_W-1:0] COARSE_STEP_RST = 5'd5;
    localparam logic [BAND_W-1:0]   INNER_BAND_RST  = 8'd8;
    localparam logic [BAND_W-1:0]   OUTER_BAND_RST  = 8'd16;
    localparam logic [SP_W-1:0]     SETPOINT_RST    = 7'd25;

    typedef enum logic [1:0] {
        MODE_MONITOR = 2'd0,
        MODE_SET     = 2'd1,
        MODE_CONTROL = 2'd2
    } mode_t;

    typedef struct packed {
        logic [SP_W-1:0]     low_limit;
        logic [SP_W-1:0]     high_limit;
        logic [FINE_W-1:0]   fine_step;
        logic [COARSE_W-1:0] coarse_step;
        logic [BAND_W-1:0]   inner_band;
        logic [BAND_W-1:0]   outer_band;
    } tmc_cfg_t;

    typedef struct packed {
        mode_t           mode;
        logic [SP_W-1:0] setpoint;
        logic            heater;
        logic            fan;
    } tmc_state_t;

endpackage

@@ hdl/tmc_cfg_regs.sv @@
`timescale 1ns / 1ps

module tmc_cfg_regs
    import tmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output tmc_cfg_t              cfg
);

    tmc_cfg_t cfg_reg;
    tmc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_LOW_LIMIT:   cfg_next.low_limit   = wr_data[SP_W-1:0];
                CFG_HIGH_LIMIT:  cfg_next.high_limit  = wr_data[SP_W-1:0];
                CFG_FINE_STEP:   cfg_next.fine_step   = wr_data[FINE_W-1:0];
                CFG_COARSE_STEP: cfg_next.coarse_step = wr_data[COARSE_W-1:0];
                CFG_INNER_BAND:  cfg_next.inner_band  = wr_data[BAND_W-1:0];
                CFG_OUTER_BAND:  cfg_next.outer_band  = wr_data[BAND_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_limit   <= LOW_LIMIT_RST;
            cfg_reg.high_limit  <= HIGH_LIMIT_RST;
            cfg_reg.fine_step   <= FINE_STEP_RST;
            cfg_reg.coarse_step <= COARSE_STEP_RST;
            cfg_reg.inner_band  <= INNER_BAND_RST;
            cfg_reg.outer_band  <= OUTER_BAND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/tmc_step.sv @@
`timescale 1ns / 1ps

module tmc_step
    import tmc_pkg::*;
(
    input  tmc_cfg_t                  cfg,
    input  tmc_state_t                cur,
    input  logic signed [TEMP_W-1:0]  temperature,
    input  logic [KEY_W-1:0]          key_mask,
    output tmc_state_t                nxt
);

    // compare width covers setpoint*16 plus or minus a full band
    localparam int CMP_W  = 14;
    // step width covers setpoint plus or minus a coarse step
    localparam int STEP_W = 9;

    logic signed [CMP_W-1:0]  t_ext;
    logic signed [CMP_W-1:0]  sp16;
    logic signed [CMP_W-1:0]  ib;
    logic signed [CMP_W-1:0]  ob;
    logic signed [STEP_W-1:0] s_raw;
    logic signed [STEP_W-1:0] s_lo;
    logic signed [STEP_W-1:0] lo_ext;
    logic signed [STEP_W-1:0] hi_ext;
    logic signed [STEP_W-1:0] fine_ext;
    logic signed [STEP_W-1:0] coarse_ext;
    logic signed [STEP_W-1:0] sp_ext;
    logic [SP_W-1:0]          s_clamped;
    logic                     heat_c;
    logic                     fan_c;

    assign t_ext      = CMP_W'(temperature);
    assign sp16       = $signed({3'b000, cur.setpoint, 4'b0000});
    assign ib         = $signed({6'b000000, cfg.inner_band});
    assign ob         = $signed({6'b000000, cfg.outer_band});
    assign sp_ext     = $signed({2'b00, cur.setpoint});
    assign lo_ext     = $signed({2'b00, cfg.low_limit});
    assign hi_ext     = $signed({2'b00, cfg.high_limit});
    assign fine_ext   = $signed({5'b00000, cfg.fine_step});
    assign coarse_ext = $signed({4'b0000, cfg.coarse_step});

    // bang-bang rule with deadband, first match wins
    always_comb
    begin
        heat_c = cur.heater;
        fan_c  = cur.fan;
        if (cur.mode == MODE_CONTROL)
        begin
            priority if (t_ext <= sp16 - ob)
            begin
                heat_c = 1'b1;
                fan_c  = 1'b0;
            end
            else if ((t_ext >= sp16 - ib) && (t_ext <= sp16 + ib))
            begin
                heat_c = 1'b0;
                fan_c  = 1'b0;
            end
            else if (t_ext >= sp16 + ob)
            begin
                heat_c = 1'b0;
                fan_c  = 1'b1;
            end
            else
            begin
                // between the bands, outputs kept
                heat_c = cur.heater;
                fan_c  = cur.fan;
            end
        end
    end

    // setpoint step then clamp, high limit last
    always_comb
    begin
        priority if (key_mask[4])
            s_raw = sp_ext + fine_ext;
        else if (key_mask[5])
            s_raw = sp_ext - fine_ext;
        else if (key_mask[6])
            s_raw = sp_ext + coarse_ext;
        else
            s_raw = sp_ext - coarse_ext;
        s_lo = (s_raw < lo_ext) ? lo_ext : s_raw;
        s_clamped = (s_lo > hi_ext) ? cfg.high_limit : s_lo[SP_W-1:0];
    end

    // key handling, S1 highest priority
    always_comb
    begin
        nxt.mode     = cur.mode;
        nxt.setpoint = cur.setpoint;
        nxt.heater   = heat_c;
        nxt.fan      = fan_c;
        priority if (key_mask[0])
        begin
            nxt.mode   = MODE_MONITOR;
            nxt.heater = 1'b0;
            nxt.fan    = 1'b0;
        end
        else if (key_mask[1])
        begin
            nxt.mode   = MODE_SET;
            nxt.heater = 1'b0;
            nxt.fan    = 1'b0;
        end
        else if (key_mask[2])
        begin
            nxt.mode = MODE_CONTROL;
        end
        else if ((cur.mode == MODE_SET) && !key_mask[3] && (key_mask[7:4] != 4'b0000))
        begin
            nxt.setpoint = s_clamped;
        end
        else
        begin
            // no key that acts, setpoint unchanged
            nxt.setpoint = cur.setpoint;
        end
    end

endmodule

@@ hdl/thermostat_mode_controller_unit.sv @@
`timescale 1ns / 1ps
// channel | direction | handshake                | payload
// --------+-----------+--------------------------+----------------------------------------
// in      | input     | in_valid / in_stall      | temperature, key_mask
// out     | output    | out_valid / out_stall    | heater_on, fan_on, mode, setpoint,
//         |           |                          | show_setpoint
// cfg     | input     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; an item's result shows on the output
// once it has passed the input register and then the state register that doubles as the result
// the state update is one pass of compare and add logic between those two registers
// reset clears mode to monitor, setpoint to 25, heater and fan off, limits to defaults
// out_stall holds the result; the input register keeps taking items until it is full
// cfg_ready is always high

module thermostat_mode_controller_unit
    import tmc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [TEMP_W-1:0] temperature,
    input  logic [KEY_W-1:0]         key_mask,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     heater_on,
    output logic                     fan_on,
    output logic [1:0]               mode,
    output logic [SP_W-1:0]          setpoint,
    output logic                     show_setpoint,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    tmc_cfg_t cfg;

    // input register
    logic                     in_vld_reg;
    logic                     in_vld_next;
    logic signed [TEMP_W-1:0] temp_reg;
    logic [KEY_W-1:0]         key_reg;

    // controller state, also the result register
    tmc_state_t st_reg;
    tmc_state_t st_next;
    tmc_state_t st_calc;
    logic       out_vld_reg;
    logic       out_vld_next;

    logic out_free;
    logic advance;
    logic in_take;

    assign cfg_ready = 1'b1;

    tmc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    tmc_step u_step (
        .cfg         (cfg),
        .cur         (st_reg),
        .temperature (temp_reg),
        .key_mask    (key_reg),
        .nxt         (st_calc)
    );

    // result slot is free when empty or being taken this cycle
    assign out_free = !out_vld_reg || !out_stall;
    // buffered item is processed and lands in the state register
    assign advance  = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        out_vld_next = advance ? 1'b1 : (out_stall ? out_vld_reg : 1'b0);
        st_next = advance ? st_calc : st_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            st_reg.mode     <= MODE_MONITOR;
            st_reg.setpoint <= SETPOINT_RST;
            st_reg.heater   <= 1'b0;
            st_reg.fan      <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            st_reg      <= st_next;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            temp_reg <= temperature;
            key_reg  <= key_mask;
        end
    end

    assign out_valid     = out_vld_reg;
    assign heater_on     = st_reg.heater;
    assign fan_on        = st_reg.fan;
    assign mode          = st_reg.mode;
    assign setpoint      = st_reg.setpoint;
    assign show_setpoint = (st_reg.mode == MODE_SET);

`ifndef SYNTHESIS
    // heater and fan are never driven together
    assert property (@(posedge clk) disable iff (!rst_n) !(heater_on && fan_on))
        else $error("heater and fan both on");

    // a held result keeps the controller state frozen
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(st_reg) && out_valid))
        else $error("state moved under a stalled result");

    // setpoint only moves while in set mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (setpoint != $past(setpoint)) |-> ($past(st_reg.mode) == MODE_SET))
        else $error("setpoint changed outside set mode");

    // every processed item produces a valid result next cycle
    assert property (@(posedge clk) disable iff (!rst_n) advance |=> out_valid)
        else $error("processed item lost");
`endif

endmodule

@@ bench/tb_thermostat_mode_controller_unit.sv @@
`timescale 1ns / 1ps

module tb_thermostat_mode_controller_unit;
    import tmc_pkg::*;

    // sample range of the sensor, sixteenths of a degree
    localparam int TEMP_MIN = -880;
    localparam int TEMP_MAX = 2000;

    // generous ceiling on run length, in clock cycles
    localparam int CYCLE_LIMIT = 500_000;

    // an index past the last register, the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd6;

    // one bit per front panel key, S1 has top priority
    localparam logic [KEY_W-1:0] KEY_S1 = 8'h01;
    localparam logic [KEY_W-1:0] KEY_S2 = 8'h02;
    localparam logic [KEY_W-1:0] KEY_S3 = 8'h04;
    localparam logic [KEY_W-1:0] KEY_S4 = 8'h08;
    localparam logic [KEY_W-1:0] KEY_S5 = 8'h10;
    localparam logic [KEY_W-1:0] KEY_S6 = 8'h20;
    localparam logic [KEY_W-1:0] KEY_S7 = 8'h40;
    localparam logic [KEY_W-1:0] KEY_S8 = 8'h80;

    // a scan item waiting to be sent; near items place the sample around
    // the setpoint that holds when the item goes out on the port
    typedef struct {
        logic            near;
        int              value;
        int unsigned     pick;
        logic [KEY_W-1:0] keys;
    } scan_item_t;

    // what the block should show after one scan item
    typedef struct packed {
        logic            heater;
        logic            fan;
        mode_t           mode;
        logic [SP_W-1:0] setpoint;
        logic            show;
    } reading_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic signed [TEMP_W-1:0] temperature = '0;
    logic [KEY_W-1:0]         key_mask = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     heater_on;
    logic                     fan_on;
    logic [1:0]               mode;
    logic [SP_W-1:0]          setpoint;
    logic                     show_setpoint;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    // items waiting for the port, and readings waiting for the output
    scan_item_t scan_items[$];
    reading_t   expected_readings[$];

    // shadow copy of the block's registers and settings
    tmc_state_t st;
    tmc_cfg_t   settings;

    scan_item_t cur_item;
    int         gap_left = 0;
    int         stall_left = 0;
    int         errors = 0;
    int         cycles = 0;
    // items taken off the queue whose reading has not been checked yet
    int         in_flight = 0;
    // no gaps and no stalls while set
    logic       calm = 1'b0;

    thermostat_mode_controller_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .temperature   (temperature),
        .key_mask      (key_mask),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .heater_on     (heater_on),
        .fan_on        (fan_on),
        .mode          (mode),
        .setpoint      (setpoint),
        .show_setpoint (show_setpoint),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // run ceiling, a hung handshake ends here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // thermostat step: deadband control in control mode, then key handling
    function automatic reading_t advance_thermostat(input logic signed [TEMP_W-1:0] t,
                                                    input logic [KEY_W-1:0] k);
        int       sp;
        int       tv;
        int       s;
        reading_t r;
        sp = int'(st.setpoint) * 16;
        tv = t;
        // bands are tried in order, so with inner wider than outer the heat rule wins
        if (st.mode == MODE_CONTROL)
        begin
            if (tv <= sp - int'(settings.outer_band))
            begin
                st.heater = 1'b1;
                st.fan    = 1'b0;
            end
            else if (tv >= sp - int'(settings.inner_band) && tv <= sp + int'(settings.inner_band))
            begin
                st.heater = 1'b0;
                st.fan    = 1'b0;
            end
            else if (tv >= sp + int'(settings.outer_band))
            begin
                st.heater = 1'b0;
                st.fan    = 1'b1;
            end
        end
        // only the highest priority key acts
        if ((k & KEY_S1) != 0)
        begin
            st.mode   = MODE_MONITOR;
            st.heater = 1'b0;
            st.fan    = 1'b0;
        end
        else if ((k & KEY_S2) != 0)
        begin
            st.mode   = MODE_SET;
            st.heater = 1'b0;
            st.fan    = 1'b0;
        end
        else if ((k & KEY_S3) != 0)
            st.mode = MODE_CONTROL;
        else if (k != 0 && st.mode == MODE_SET && (k & KEY_S4) == 0)
        begin
            s = st.setpoint;
            if ((k & KEY_S5) != 0)
                s += settings.fine_step;
            else if ((k & KEY_S6) != 0)
                s -= settings.fine_step;
            else if ((k & KEY_S7) != 0)
                s += settings.coarse_step;
            else
                s -= settings.coarse_step;
            // low limit first, so crossed limits settle on the high one
            if (s < int'(settings.low_limit))
                s = settings.low_limit;
            if (s > int'(settings.high_limit))
                s = settings.high_limit;
            st.setpoint = s[SP_W-1:0];
        end
        r.heater   = st.heater;
        r.fan      = st.fan;
        r.mode     = st.mode;
        r.setpoint = st.setpoint;
        r.show     = (st.mode == MODE_SET);
        return r;
    endfunction

    // turn a queued item into the sample that goes out on the port
    function automatic logic signed [TEMP_W-1:0] scan_temperature(input scan_item_t it);
        int span;
        int t;
        if (it.near)
        begin
            span = (settings.inner_band > settings.outer_band) ?
                   int'(settings.inner_band) : int'(settings.outer_band);
            span += 24;
            t = int'(st.setpoint) * 16 + int'(it.pick % (2 * span + 1)) - span;
        end
        else
            t = it.value;
        if (t < TEMP_MIN)
            t = TEMP_MIN;
        if (t > TEMP_MAX)
            t = TEMP_MAX;
        return t[TEMP_W-1:0];
    endfunction

    // idle length: mostly short, now and then long
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // driver: predicts each accepted item, then offers the next one
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                expected_readings.push_back(advance_thermostat(temperature, key_mask));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (scan_items.size() > 0)
                begin
                    cur_item = scan_items.pop_front();
                    in_flight++;
                    // state here is the one the item will meet
                    temperature <= scan_temperature(cur_item);
                    key_mask    <= cur_item.keys;
                    in_valid    <= 1'b1;
                    if (!calm && $urandom_range(0, 99) < 40)
                        gap_left = pick_pause();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each accepted reading and applies backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_readings.size() == 0)
                    report_mismatch("unexpected reading", 1, 0);
                else
                begin
                    reading_t want;
                    want = expected_readings.pop_front();
                    in_flight--;
                    if (heater_on !== want.heater)
                        report_mismatch("heater_on", heater_on, want.heater);
                    if (fan_on !== want.fan)
                        report_mismatch("fan_on", fan_on, want.fan);
                    if (mode !== want.mode)
                        report_mismatch("mode", mode, want.mode);
                    if (setpoint !== want.setpoint)
                        report_mismatch("setpoint", setpoint, want.setpoint);
                    if (show_setpoint !== want.show)
                        report_mismatch("show_setpoint", show_setpoint, want.show);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < 30)
            begin
                stall_left = pick_pause() - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic push_fixed(input int t, input logic [KEY_W-1:0] k);
        scan_item_t it;
        it.near  = 1'b0;
        it.value = t;
        it.pick  = 0;
        it.keys  = k;
        scan_items.push_back(it);
    endtask

    // random key mix: mostly idle scans and set-mode steps, some mode changes,
    // some multi-key noise
    function automatic logic [KEY_W-1:0] random_keys();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return '0;
        if (r < 49)
            return KEY_S1;
        if (r < 54)
            return KEY_S2;
        if (r < 60)
            return KEY_S3;
        if (r < 85)
            return KEY_S4 << $urandom_range(0, 4);
        if (r < 95)
            return KEY_W'($urandom_range(0, 255));
        return KEY_W'($urandom_range(1, 31)) << 3;
    endfunction

    task automatic queue_random_items(input int n);
        scan_item_t it;
        int         r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            it.near  = (r < 75);
            it.pick  = $urandom;
            if (r < 78)
                it.value = (r & 1) ? TEMP_MIN : TEMP_MAX;
            else
                it.value = int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
            it.keys = random_keys();
            scan_items.push_back(it);
        end
    endtask

    // wait for the port to drain and every reading to come back
    task automatic settle();
        while (scan_items.size() != 0 || in_flight != 0 || in_valid || gap_left != 0 ||
               expected_readings.size() != 0)
            @(posedge clk);
    endtask

    // one register write; the model follows at the accepting edge
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_LOW_LIMIT:   settings.low_limit   = val[SP_W-1:0];
            CFG_HIGH_LIMIT:  settings.high_limit  = val[SP_W-1:0];
            CFG_FINE_STEP:   settings.fine_step   = val[FINE_W-1:0];
            CFG_COARSE_STEP: settings.coarse_step = val[COARSE_W-1:0];
            CFG_INNER_BAND:  settings.inner_band  = val[BAND_W-1:0];
            CFG_OUTER_BAND:  settings.outer_band  = val[BAND_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input tmc_cfg_t c, input logic poke_unused);
        write_setting(CFG_LOW_LIMIT,   CFG_DATA_W'(c.low_limit));
        write_setting(CFG_HIGH_LIMIT,  CFG_DATA_W'(c.high_limit));
        write_setting(CFG_FINE_STEP,   CFG_DATA_W'(c.fine_step));
        write_setting(CFG_COARSE_STEP, CFG_DATA_W'(c.coarse_step));
        write_setting(CFG_INNER_BAND,  c.inner_band);
        write_setting(CFG_OUTER_BAND,  c.outer_band);
        if (poke_unused)
            write_setting(CFG_UNUSED_IDX, 8'hFF);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        tmc_cfg_t c;
        st.mode              = MODE_MONITOR;
        st.setpoint          = SETPOINT_RST;
        st.heater            = 1'b0;
        st.fan               = 1'b0;
        settings.low_limit   = LOW_LIMIT_RST;
        settings.high_limit  = HIGH_LIMIT_RST;
        settings.fine_step   = FINE_STEP_RST;
        settings.coarse_step = COARSE_STEP_RST;
        settings.inner_band  = INNER_BAND_RST;
        settings.outer_band  = OUTER_BAND_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass at reset settings: setpoint 25 is 400 sixteenths,
        // inner band 8, outer band 16
        push_fixed(TEMP_MIN, '0);                      // monitor ignores the sample
        push_fixed(TEMP_MAX, KEY_S8);                  // step key outside set mode
        push_fixed(400, KEY_S3);                       // enter control
        push_fixed(384, '0);                           // exactly sp - outer: heat
        push_fixed(390, '0);                           // between bands: hold
        push_fixed(392, '0);                           // sp - inner edge: off
        push_fixed(408, '0);                           // sp + inner edge: off
        push_fixed(416, '0);                           // exactly sp + outer: fan
        push_fixed(410, '0);                           // between bands: hold fan
        push_fixed(TEMP_MAX, '0);
        push_fixed(TEMP_MIN, '0);
        push_fixed(400, 8'hFF);                        // all keys: S1 wins
        push_fixed(TEMP_MIN, KEY_S2 | KEY_S5 | KEY_S8); // S2 beats the step keys
        push_fixed(0, KEY_S5);
        push_fixed(0, KEY_S6);
        push_fixed(0, KEY_S7);
        push_fixed(0, KEY_S8);
        push_fixed(0, KEY_S4 | KEY_S5);                // S4 blocks the step
        push_fixed(0, KEY_S8);
        push_fixed(0, KEY_S8);                         // below low limit, clamped
        push_fixed(TEMP_MIN, KEY_S3);                  // set mode runs no control
        push_fixed(TEMP_MIN, KEY_S4 | KEY_S5 | KEY_S6 | KEY_S7 | KEY_S8);
        push_fixed(TEMP_MIN, KEY_S2);                  // heat decided, then forced off
        push_fixed(0, '0);                             // set mode, no key
        push_fixed(0, KEY_S1);
        settle();

        // random phases, each under its own settings; the block is idle between them
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: c = '{low_limit: 7'd0, high_limit: 7'd125, fine_step: 4'd15,
                         coarse_step: 5'd31, inner_band: 8'd0, outer_band: 8'd0};
                1: c = '{low_limit: 7'd125, high_limit: 7'd125, fine_step: 4'd0,
                         coarse_step: 5'd0, inner_band: 8'd255, outer_band: 8'd255};
                // crossed limits and an inner band wider than the outer one
                2: c = '{low_limit: 7'd100, high_limit: 7'd30, fine_step: 4'd7,
                         coarse_step: 5'd19, inner_band: 8'd40, outer_band: 8'd20};
                3: c = '{low_limit: SP_W'($urandom_range(0, 60)),
                         high_limit: SP_W'($urandom_range(40, 125)),
                         fine_step: FINE_W'($urandom_range(0, 15)),
                         coarse_step: COARSE_W'($urandom_range(0, 31)),
                         inner_band: BAND_W'($urandom_range(0, 64)),
                         outer_band: BAND_W'($urandom_range(0, 96))};
                4: c = '{low_limit: SP_W'($urandom_range(0, 125)),
                         high_limit: SP_W'($urandom_range(0, 125)),
                         fine_step: FINE_W'($urandom_range(0, 15)),
                         coarse_step: COARSE_W'($urandom_range(0, 31)),
                         inner_band: BAND_W'($urandom_range(0, 255)),
                         outer_band: BAND_W'($urandom_range(0, 255))};
                default: c = '{low_limit: LOW_LIMIT_RST, high_limit: HIGH_LIMIT_RST,
                               fine_step: FINE_STEP_RST, coarse_step: COARSE_STEP_RST,
                               inner_band: INNER_BAND_RST, outer_band: OUTER_BAND_RST};
            endcase
            apply_settings(c, p == 1);
            // one phase runs back to back with no idling at all
            calm = (p == 3);
            queue_random_items(200);
            settle();
        end

        // leave room for any stray reading
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
